### hw/rtl/drtm_pkg.sv
// ----------------------------------------------------------------------------
// drtm_pkg
// Shared types and constants of the descriptor ratio-test matcher.
// ----------------------------------------------------------------------------
package drtm_pkg;

  localparam int RefDepth  = 512;
  localparam int DescLen   = 128;
  localparam int Lanes     = 8;
  localparam int Words     = (DescLen + Lanes - 1) / Lanes;
  localparam int WordW     = $clog2(Words);
  localparam int RefW      = $clog2(RefDepth);
  localparam int CountW    = $clog2(RefDepth + 1);
  localparam int MemDepth  = RefDepth * Words;
  localparam int MemAw     = $clog2(MemDepth);
  localparam int DistW     = 23;
  localparam int SqW       = 16;
  localparam int LaneSumW  = SqW + $clog2(Lanes) + 1;

  localparam logic [DistW-1:0] DistMax  = '1;
  localparam logic [15:0]      MatchMax = '1;
  localparam logic [15:0]      RatioRst = 16'd41943;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Lane row input: reference and query words plus valid and last strobes.
  typedef struct packed {
    logic            valid;
    logic            last;
    logic [Lanes*8-1:0] ref_word;
    logic [Lanes*8-1:0] qry_word;
  } cell_in_t;

  // Word sum leaving the lane row toward the accumulator.
  typedef struct packed {
    logic                valid;
    logic                last;
    logic [LaneSumW-1:0] sum;
  } word_sum_t;

endpackage

### hw/rtl/drtm_ram.sv
// ----------------------------------------------------------------------------
// drtm_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module drtm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/drtm_cell.sv
// ----------------------------------------------------------------------------
// drtm_cell
// One lane cell: squares a byte difference and adds it to the partial sum
// handed in by its left neighbor, registering the result for the next cell.
// ----------------------------------------------------------------------------
module drtm_cell (
  input  logic                               clk,
  input  logic [7:0]                         ref_byte,
  input  logic [7:0]                         qry_byte,
  input  logic [drtm_pkg::LaneSumW-1:0]      sum_in,
  output logic [drtm_pkg::LaneSumW-1:0]      sum_out
);

  logic [8:0]                    diff;
  logic [7:0]                    mag;
  logic [drtm_pkg::SqW-1:0]      sq;

  always_comb begin
    diff = {1'b0, qry_byte} - {1'b0, ref_byte};
    mag  = diff[8] ? 8'(-diff) : diff[7:0];
    sq   = drtm_pkg::SqW'(mag) * drtm_pkg::SqW'(mag);
  end

  always_ff @(posedge clk) begin
    sum_out <= sum_in + drtm_pkg::LaneSumW'(sq);
  end

endmodule

### hw/rtl/drtm_lane_row.sv
// ----------------------------------------------------------------------------
// drtm_lane_row
// Chain of lane cells. Operands enter skewed so that each cell sees its bytes
// as its left neighbor's partial sum arrives; the partial sum ripples down the row.
// ----------------------------------------------------------------------------
module drtm_lane_row (
  input  logic                 clk,
  input  logic                 rst,
  input  drtm_pkg::cell_in_t   word_in,
  output drtm_pkg::word_sum_t  sum_out
);

  localparam int L = drtm_pkg::Lanes;

  // Skew registers: delay line of operand bytes per lane.
  logic [7:0] ref_skew [L][L];
  logic [7:0] qry_skew [L][L];
  logic [drtm_pkg::LaneSumW-1:0] chain [L+1];
  logic [L-1:0] vld_pipe;
  logic [L-1:0] last_pipe;

  assign chain[0] = '0;

  for (genvar k = 0; k < L; k++) begin : g_lane
    always_ff @(posedge clk) begin
      ref_skew[k][0] <= word_in.ref_word[k*8 +: 8];
      qry_skew[k][0] <= word_in.qry_word[k*8 +: 8];
    end
    for (genvar s = 1; s < L; s++) begin : g_skew
      always_ff @(posedge clk) begin
        ref_skew[k][s] <= ref_skew[k][s-1];
        qry_skew[k][s] <= qry_skew[k][s-1];
      end
    end
    drtm_cell u_cell (
      .clk      (clk),
      .ref_byte (ref_skew[k][k]),
      .qry_byte (qry_skew[k][k]),
      .sum_in   (chain[k]),
      .sum_out  (chain[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_pipe  <= '0;
      last_pipe <= '0;
    end else begin
      vld_pipe  <= L'({vld_pipe, word_in.valid});
      last_pipe <= L'({last_pipe, word_in.last});
    end
  end

  // Cell k's output is registered once more than its skew, so the sum of
  // the final cell lines up with bit L-1 once it is registered into vld_out.
  logic vld_out, last_out;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out  <= 1'b0;
      last_out <= 1'b0;
    end else begin
      vld_out  <= vld_pipe[L-1];
      last_out <= last_pipe[L-1];
    end
  end

  assign sum_out = '{valid: vld_out, last: last_out, sum: chain[L]};

endmodule

### hw/rtl/descriptor_ratio_test_matcher_top.sv
// ----------------------------------------------------------------------------
// descriptor_ratio_test_matcher_top
// Brute-force descriptor matcher with a nearest/second-nearest ratio test.
// ----------------------------------------------------------------------------
// Load and intermediate query chunks do not stall the input. The last chunk of
// a query starts a scan that reads one stored 64-bit word per cycle from the
// reference RAM, so after that transfer the input stalls through the scan, the
// drain of the lane row and the loading of the result; with no references
// stored the scan and drain are skipped. The stall grows if the previous
// result is still waiting to be taken. Each word flows through a row of eight
// lane cells that accumulate squared byte differences; a per-reference
// accumulator then updates best and second best. A result waits in an output
// register and is held until taken.
module descriptor_ratio_test_matcher_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [7:0]  byte0,
  input  logic [7:0]  byte1,
  input  logic [7:0]  byte2,
  input  logic [7:0]  byte3,
  input  logic [7:0]  byte4,
  input  logic [7:0]  byte5,
  input  logic [7:0]  byte6,
  input  logic [7:0]  byte7,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        matched,
  output logic [22:0] best_distance,
  output logic [22:0] second_distance,
  output logic [15:0] match_count,
  output logic        status
);

  localparam int WordW  = drtm_pkg::WordW;
  localparam int CountW = drtm_pkg::CountW;
  localparam int MemAw  = drtm_pkg::MemAw;
  localparam int DistW  = drtm_pkg::DistW;
  localparam int LW     = drtm_pkg::Lanes * 8;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_OUT   = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [15:0]       ratio_sq;
  logic [CountW-1:0] ref_count;
  logic [WordW-1:0]  load_idx;
  logic [WordW-1:0]  qry_idx;
  logic [15:0]       match_cnt;
  logic [LW-1:0]     qbuf [drtm_pkg::Words];

  logic [LW-1:0] chunk;
  assign chunk = {byte7, byte6, byte5, byte4, byte3, byte2, byte1, byte0};

  drtm_pkg::op_t op;
  assign op = drtm_pkg::op_t'(opcode);

  logic take;
  assign in_stall = (state != ST_IDLE);
  assign take     = in_valid && !in_stall;

  // Reference RAM write.
  logic             ram_we;
  logic [MemAw-1:0] ram_waddr;
  logic [MemAw-1:0] ram_raddr;
  logic [LW-1:0]    ram_rdata;
  logic             full;
  assign full      = (ref_count >= CountW'(drtm_pkg::RefDepth));
  assign ram_we    = take && (op == drtm_pkg::OP_LOAD) && !full;
  assign ram_waddr = MemAw'(ref_count) * MemAw'(drtm_pkg::Words) + MemAw'(load_idx);

  drtm_ram #(.Width(LW), .Depth(drtm_pkg::MemDepth)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (chunk),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Scan address generator.
  logic [MemAw-1:0] scan_addr;
  logic [MemAw-1:0] scan_end;
  logic             scan_rd;      // a read issued this cycle
  logic             rd_vld;       // RAM data valid this cycle
  logic [WordW-1:0] rd_word;
  logic [WordW-1:0] issue_word;
  assign ram_raddr  = scan_addr;
  assign scan_rd    = (state == ST_SCAN);
  assign issue_word = WordW'(scan_addr);

  drtm_pkg::cell_in_t  row_in;
  drtm_pkg::word_sum_t row_out;

  always_comb begin
    row_in.valid    = rd_vld;
    row_in.last     = rd_vld && (rd_word == WordW'(drtm_pkg::Words - 1));
    row_in.ref_word = ram_rdata;
    row_in.qry_word = qbuf[rd_word];
  end

  drtm_lane_row u_row (
    .clk     (clk),
    .rst     (rst),
    .word_in (row_in),
    .sum_out (row_out)
  );

  // Per-reference accumulator and best/second tracking.
  logic [DistW:0]   acc;
  logic [DistW:0]   acc_sum;
  logic [DistW-1:0] ref_dist;
  logic [DistW-1:0] best, second;
  logic [CountW-1:0] refs_done;

  assign acc_sum  = acc + (DistW+1)'(row_out.sum);
  assign ref_dist = acc_sum[DistW] ? drtm_pkg::DistMax : acc_sum[DistW-1:0];

  // Ratio test operands.
  logic [DistW+15:0] lhs, rhs;
  logic              pass;
  assign lhs  = {best, 16'd0};
  assign rhs  = (DistW+16)'(second) * (DistW+16)'(ratio_sq);
  assign pass = (best == '0) || (ref_count == CountW'(1)) || (lhs < rhs);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (take && op == drtm_pkg::OP_QUERY
            && qry_idx == WordW'(drtm_pkg::Words - 1)) begin
          state_next = (ref_count == '0) ? ST_OUT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_addr == scan_end) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (refs_done == ref_count) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ratio_sq  <= drtm_pkg::RatioRst;
      ref_count <= '0;
      load_idx  <= '0;
      qry_idx   <= '0;
      match_cnt <= '0;
      out_valid <= 1'b0;
      rd_vld    <= 1'b0;
      acc       <= '0;
      refs_done <= '0;
      best      <= drtm_pkg::DistMax;
      second    <= drtm_pkg::DistMax;
    end else begin
      state  <= state_next;
      rd_vld <= scan_rd;
      if (cfg_we) ratio_sq <= cfg_wdata;
      if (out_valid && !out_stall) out_valid <= 1'b0;

      if (take) begin
        unique case (op)
          drtm_pkg::OP_CLEAR: begin
            ref_count <= '0;
            load_idx  <= '0;
            match_cnt <= '0;
          end
          drtm_pkg::OP_LOAD: begin
            if (!full) begin
              if (load_idx == WordW'(drtm_pkg::Words - 1)) begin
                load_idx  <= '0;
                ref_count <= ref_count + CountW'(1);
              end else begin
                load_idx <= load_idx + WordW'(1);
              end
            end
          end
          drtm_pkg::OP_QUERY: begin
            if (qry_idx == WordW'(drtm_pkg::Words - 1)) begin
              qry_idx   <= '0;
              acc       <= '0;
              refs_done <= '0;
              best      <= drtm_pkg::DistMax;
              second    <= drtm_pkg::DistMax;
            end else begin
              qry_idx <= qry_idx + WordW'(1);
            end
          end
          default: ;
        endcase
      end

      if (row_out.valid) begin
        if (row_out.last) begin
          acc       <= '0;
          refs_done <= refs_done + CountW'(1);
          if (ref_dist < best) begin
            second <= best;
            best   <= ref_dist;
          end else if (ref_dist < second) begin
            second <= ref_dist;
          end
        end else begin
          acc <= acc_sum;
        end
      end

      if (state == ST_OUT && !out_valid) begin
        out_valid <= 1'b1;
        if (ref_count == '0) begin
          matched       <= 1'b0;
          best_distance <= '0;
          second_distance <= drtm_pkg::DistMax;
          status        <= 1'b1;
          match_count   <= match_cnt;
        end else begin
          matched         <= pass;
          best_distance   <= best;
          second_distance <= second;
          status          <= 1'b0;
          if (pass && match_cnt != drtm_pkg::MatchMax) begin
            match_cnt   <= match_cnt + 16'd1;
            match_count <= match_cnt + 16'd1;
          end else begin
            match_count <= match_cnt;
          end
        end
      end
    end
  end

  // ST_OUT is left as the result is loaded. Query buffer and scan address registers follow.
  always_ff @(posedge clk) begin
    if (take && op == drtm_pkg::OP_QUERY) qbuf[qry_idx] <= chunk;
    rd_word <= issue_word;
    if (state == ST_IDLE) begin
      scan_addr <= '0;
      scan_end  <= MemAw'(ref_count) * MemAw'(drtm_pkg::Words) - MemAw'(1);
    end else if (scan_rd && scan_addr != scan_end) begin
      scan_addr <= scan_addr + MemAw'(1);
    end
  end

  // Checks: busy stalls input, one-hot state, best <= second, stalled result held.
  assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_stall)
    else $error("input taken while busy");
  assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("state not one-hot");
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (best_distance <= second_distance))
    else $error("best above second");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped");

endmodule
